>>> hw/rtl/fca_pkg.sv
// fca_pkg: shared types and constants for the file allocation table block
// state encoding, opcodes, status codes and default sizes
// no dependencies
`default_nettype none

package fca_pkg;

    // default sizes
    localparam int DEF_NUM_BLOCKS       = 256;
    localparam int DEF_ROOT_ENTRIES     = 16;
    localparam int DEF_FIRST_DATA_BLOCK = 11;

    // request opcodes
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_APPEND = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_CHECK  = 3'd4;
    localparam logic [2:0] OP_NEXT   = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EXISTS      = 3'd1;
    localparam logic [2:0] ST_DIR_FULL    = 3'd2;
    localparam logic [2:0] ST_NO_FILE     = 3'd3;
    localparam logic [2:0] ST_NOT_EMPTY   = 3'd4;
    localparam logic [2:0] ST_DISK_FULL   = 3'd5;
    localparam logic [2:0] ST_NOT_IN_FILE = 3'd6;

    // sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIR_RD,
        S_DIR_CHK,
        S_ALLOC_WR,
        S_APP_RD,
        S_APP_CHK,
        S_WALK_CHK,
        S_WALK_RD,
        S_NEXT_RD,
        S_DEL_FREE
    } fca_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/fat_chain_allocator.sv
// Operation: a request scans the root directory slot by slot (up to
// ROOT_ENTRIES slots), then append, delete, check and next walk the chain
// link by link to finish; the result is registered at the end.
// Throughput: one request at a time; the link table, with one read and one write port, sets the pace.
// Reset: asynchronous, active low; afterwards a sweep over every block
// formats the link table, and no request is taken until it ends.
// file: top level, depends on fca_pkg
`default_nettype none

module fat_chain_allocator
    import fca_pkg::*;
#(
    parameter int NUM_BLOCKS       = DEF_NUM_BLOCKS,
    parameter int ROOT_ENTRIES     = DEF_ROOT_ENTRIES,
    parameter int FIRST_DATA_BLOCK = DEF_FIRST_DATA_BLOCK
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [63:0] file_name,
    input  wire logic [7:0]  block_number,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [2:0]       status,
    output logic [7:0]       block_value
);

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int CW = ((AW > 8) ? AW : 8) + 1;
    localparam int SW = AW + 1;
    localparam int EW = (ROOT_ENTRIES > 1) ? $clog2(ROOT_ENTRIES) : 1;

    // block number lies inside the table
    function automatic logic in_range(input logic [7:0] b);
        in_range = CW'(b) < CW'(NUM_BLOCKS);
    endfunction

    // formatted link value of one block
    function automatic logic [7:0] init_link(input logic [AW-1:0] i);
        if ((CW'(i) >= CW'(FIRST_DATA_BLOCK)) && (CW'(i) + CW'(1) < CW'(NUM_BLOCKS)))
            init_link = 8'(CW'(i) + CW'(1));
        else
            init_link = 8'd0;
    endfunction

    fca_state_t state_reg, state_next;

    logic [2:0]              op_reg, op_next;
    logic [63:0]             name_reg, name_next;
    logic [7:0]              blk_reg, blk_next;
    logic [EW-1:0]           idx_reg, idx_next;
    logic [EW-1:0]           ent_reg, ent_next;
    logic                    free_ok_reg, free_ok_next;
    logic [EW-1:0]           free_idx_reg, free_idx_next;
    logic [7:0]              first_reg, first_next;
    logic [7:0]              free_head_reg, free_head_next;
    logic [7:0]              alloc_reg, alloc_next;
    logic [7:0]              cur_reg, cur_next;
    logic [7:0]              prev_reg, prev_next;
    logic [SW-1:0]           steps_reg, steps_next;
    logic [AW-1:0]           init_reg, init_next;
    logic [ROOT_ENTRIES-1:0] valid_reg, valid_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [2:0]              status_reg, status_next;
    logic [7:0]              value_reg, value_next;

    // memories
    logic [7:0]  link_mem [NUM_BLOCKS];
    logic [63:0] name_mem [ROOT_ENTRIES];
    logic [7:0]  first_mem [ROOT_ENTRIES];
    logic [7:0]  link_rd_reg;
    logic [63:0] name_rd_reg;
    logic [7:0]  first_rd_reg;

    logic          lw_en;
    logic [AW-1:0] lw_addr;
    logic [7:0]    lw_data;
    logic [AW-1:0] lr_addr;
    logic          nw_en;
    logic [EW-1:0] nw_addr;
    logic          fw_en;
    logic [EW-1:0] fw_addr;
    logic [7:0]    fw_data;

    // helper terms
    logic          hit, last_slot, fr_ok, cur_ok, alloc_ok, walk_stop, app_more;
    logic [EW-1:0] fr_idx;
    logic [7:0]    app_link, alloc_link;

    assign hit       = valid_reg[idx_reg] && (name_rd_reg == name_reg);
    assign last_slot = idx_reg == EW'(ROOT_ENTRIES - 1);
    assign fr_ok     = free_ok_reg || !valid_reg[idx_reg];
    assign fr_idx    = free_ok_reg ? free_idx_reg : idx_reg;
    assign cur_ok    = in_range(cur_reg);
    assign alloc_ok  = in_range(alloc_reg);
    assign walk_stop = (cur_reg == 8'd0) || !cur_ok || (steps_reg >= SW'(NUM_BLOCKS));
    assign app_link  = cur_ok ? link_rd_reg : 8'd0;
    assign app_more  = (app_link != 8'd0) && (steps_reg < SW'(NUM_BLOCKS));
    assign alloc_link = alloc_ok ? link_rd_reg : 8'd0;

    assign req_ready   = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign block_value = value_reg;

    // link table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (lw_en)
            link_mem[lw_addr] <= lw_data;
        link_rd_reg <= link_mem[lr_addr];
    end

    // root directory names and first blocks
    always_ff @(posedge clk)
    begin
        if (nw_en)
            name_mem[nw_addr] <= name_reg;
        if (fw_en)
            first_mem[fw_addr] <= fw_data;
        name_rd_reg  <= name_mem[idx_reg];
        first_rd_reg <= first_mem[idx_reg];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (init_reg == AW'(NUM_BLOCKS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid && req_ready)
                    state_next = S_DIR_RD;
            end
            S_DIR_RD:
                state_next = S_DIR_CHK;
            S_DIR_CHK:
            begin
                if (!hit && !last_slot)
                    state_next = S_DIR_RD;
                else if (!hit)
                    state_next = S_IDLE;
                else
                begin
                    case (op_reg) inside
                        OP_APPEND:
                            state_next = (free_head_reg == 8'd0) ? S_IDLE : S_ALLOC_WR;
                        OP_DELETE, OP_CHECK, OP_NEXT:
                            state_next = S_WALK_CHK;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_ALLOC_WR:
                state_next = (first_reg == 8'd0) ? S_IDLE : S_APP_RD;
            S_APP_RD:
                state_next = S_APP_CHK;
            S_APP_CHK:
                state_next = app_more ? S_APP_RD : S_IDLE;
            S_WALK_CHK:
            begin
                if (walk_stop)
                    state_next = S_IDLE;
                else if (cur_reg == blk_reg)
                    state_next = S_NEXT_RD;
                else
                    state_next = S_WALK_RD;
            end
            S_WALK_RD:
                state_next = S_WALK_CHK;
            S_NEXT_RD:
                state_next = (op_reg == OP_DELETE) ? S_DEL_FREE : S_IDLE;
            S_DEL_FREE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        op_next        = op_reg;
        name_next      = name_reg;
        blk_next       = blk_reg;
        idx_next       = idx_reg;
        ent_next       = ent_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        first_next     = first_reg;
        free_head_next = free_head_reg;
        alloc_next     = alloc_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        init_next      = init_reg;
        valid_next     = valid_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        lw_en          = 1'b0;
        lw_addr        = AW'(cur_reg);
        lw_data        = 8'd0;
        lr_addr        = AW'(cur_reg);
        nw_en          = 1'b0;
        nw_addr        = fr_idx;
        fw_en          = 1'b0;
        fw_addr        = ent_reg;
        fw_data        = 8'd0;

        // result transfer
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            // format sweep
            S_INIT:
            begin
                lw_en     = 1'b1;
                lw_addr   = init_reg;
                lw_data   = init_link(init_reg);
                init_next = init_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    op_next      = opcode;
                    name_next    = file_name;
                    blk_next     = block_number;
                    idx_next     = '0;
                    free_ok_next = 1'b0;
                end
            end
            // directory compare and dispatch
            S_DIR_CHK:
            begin
                if (!valid_reg[idx_reg] && !free_ok_reg)
                begin
                    free_ok_next  = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (!hit && !last_slot)
                    idx_next = idx_reg + EW'(1);
                else
                begin
                    ent_next   = idx_reg;
                    first_next = first_rd_reg;
                    cur_next   = first_rd_reg;
                    steps_next = '0;
                    alloc_next = free_head_reg;
                    lr_addr    = AW'(free_head_reg);
                    value_next = 8'd0;
                    status_next = ST_OK;
                    case (op_reg) inside
                        OP_CREATE:
                        begin
                            if (hit)
                                status_next = ST_EXISTS;
                            else if (!fr_ok)
                                status_next = ST_DIR_FULL;
                            else
                            begin
                                nw_en   = 1'b1;
                                fw_en   = 1'b1;
                                fw_addr = fr_idx;
                                valid_next[fr_idx] = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!hit)
                                status_next = ST_NO_FILE;
                            else if (first_rd_reg != 8'd0)
                                status_next = ST_NOT_EMPTY;
                            else
                                valid_next[idx_reg] = 1'b0;
                        end
                        OP_APPEND:
                        begin
                            if (!hit)
                                status_next = ST_NO_FILE;
                            else if (free_head_reg == 8'd0)
                                status_next = ST_DISK_FULL;
                        end
                        OP_DELETE, OP_CHECK, OP_NEXT:
                        begin
                            if (!hit)
                                status_next = ST_NO_FILE;
                        end
                        default:
                            status_next = ST_OK;
                    endcase
                    if (!hit || (op_reg != OP_APPEND && op_reg != OP_DELETE &&
                                 op_reg != OP_CHECK && op_reg != OP_NEXT) ||
                        (op_reg == OP_APPEND && free_head_reg == 8'd0))
                        rsp_valid_next = 1'b1;
                end
            end
            // take the free head and clear its link; a file with no blocks gets it as its first block
            S_ALLOC_WR:
            begin
                free_head_next = alloc_link;
                lw_en   = alloc_ok;
                lw_addr = AW'(alloc_reg);
                lw_data = 8'd0;
                if (first_reg == 8'd0)
                begin
                    fw_en          = 1'b1;
                    fw_addr        = ent_reg;
                    fw_data        = alloc_reg;
                    value_next     = alloc_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            // walk to the chain tail, then link the new block behind it
            S_APP_CHK:
            begin
                if (app_more)
                begin
                    cur_next   = app_link;
                    steps_next = steps_reg + SW'(1);
                end
                else
                begin
                    lw_en          = cur_ok;
                    lw_addr        = AW'(cur_reg);
                    lw_data        = alloc_reg;
                    value_next     = alloc_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            // membership walk
            S_WALK_CHK:
            begin
                if (walk_stop)
                begin
                    status_next    = ST_NOT_IN_FILE;
                    rsp_valid_next = 1'b1;
                end
                else if (cur_reg == blk_reg)
                    lr_addr = AW'(blk_reg);
                else
                    lr_addr = AW'(cur_reg);
            end
            S_WALK_RD:
            begin
                prev_next  = cur_reg;
                cur_next   = link_rd_reg;
                steps_next = steps_reg + SW'(1);
            end
            // successor known: finish check and next, unlink for delete
            S_NEXT_RD:
            begin
                case (op_reg)
                    OP_NEXT:
                    begin
                        value_next     = link_rd_reg;
                        rsp_valid_next = 1'b1;
                    end
                    OP_DELETE:
                    begin
                        if (first_reg == blk_reg)
                        begin
                            fw_en   = 1'b1;
                            fw_addr = ent_reg;
                            fw_data = link_rd_reg;
                        end
                        else
                        begin
                            lw_en   = 1'b1;
                            lw_addr = AW'(prev_reg);
                            lw_data = link_rd_reg;
                        end
                    end
                    default:
                        rsp_valid_next = 1'b1;
                endcase
            end
            // return the block to the free list
            S_DEL_FREE:
            begin
                lw_en          = 1'b1;
                lw_addr        = AW'(blk_reg);
                lw_data        = free_head_reg;
                free_head_next = blk_reg;
                rsp_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            valid_reg     <= '0;
            free_head_reg <= 8'(FIRST_DATA_BLOCK);
            rsp_valid_reg <= 1'b0;
            free_ok_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            valid_reg     <= valid_next;
            free_head_reg <= free_head_next;
            rsp_valid_reg <= rsp_valid_next;
            free_ok_reg   <= free_ok_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        name_reg     <= name_next;
        blk_reg      <= blk_next;
        idx_reg      <= idx_next;
        ent_reg      <= ent_next;
        free_idx_reg <= free_idx_next;
        first_reg    <= first_next;
        alloc_reg    <= alloc_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        steps_reg    <= steps_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
    end

`ifndef SYNTHESIS
    // no request is taken while a result waits
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !rsp_valid_reg)
        else $error("request ready while result pending");

    // an accepted request starts the directory scan
    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_DIR_RD))
        else $error("request did not start directory scan");

    // disk full only reported with an empty free list
    a_disk_full: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(rsp_valid_reg) && status_reg == ST_DISK_FULL) |-> (free_head_reg == 8'd0))
        else $error("disk full reported with free blocks left");

    // a block value only comes with success
    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (value_reg == 8'd0 || status_reg == ST_OK))
        else $error("block value with error status");
`endif

endmodule

`default_nettype wire

>>> tb/fca_checker.sv
// fca_checker: watches the request and response channels, predicts each status
// and block value from its own copy of the allocation table and directory
// depends on fca_pkg
`timescale 1ns / 1ps

module fca_checker
    import fca_pkg::*;
#(
    parameter int NUM_BLOCKS       = DEF_NUM_BLOCKS,
    parameter int ROOT_ENTRIES     = DEF_ROOT_ENTRIES,
    parameter int FIRST_DATA_BLOCK = DEF_FIRST_DATA_BLOCK
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic        req_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [63:0] file_name,
    input  wire logic [7:0]  block_number,
    input  wire logic        rsp_valid,
    input  wire logic        rsp_ready,
    input  wire logic [2:0]  status,
    input  wire logic [7:0]  block_value,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [2:0] st;
        logic [7:0] val;
    } outcome_t;

    // shadow file system
    logic [7:0]  links [NUM_BLOCKS];
    logic [7:0]  free_ptr;
    logic [63:0] dir_name  [ROOT_ENTRIES];
    logic        dir_used  [ROOT_ENTRIES];
    logic [7:0]  dir_first [ROOT_ENTRIES];

    outcome_t expected_outcomes[$];

    assign pending = expected_outcomes.size();

    function automatic logic [7:0] link_of(int b);
        return (b < NUM_BLOCKS) ? links[b] : 8'd0;
    endfunction

    function automatic int lookup(logic [63:0] nm);
        for (int i = 0; i < ROOT_ENTRIES; i++)
            if (dir_used[i] && dir_name[i] == nm)
                return i;
        return -1;
    endfunction

    function automatic bit chain_has(logic [7:0] first, logic [7:0] target);
        int cur;
        int steps;
        cur = first;
        steps = 0;
        while (cur != 0 && cur < NUM_BLOCKS && steps < NUM_BLOCKS)
        begin
            if (cur == target)
                return 1;
            cur = links[cur];
            steps++;
        end
        return 0;
    endfunction

    function automatic void format_disk();
        for (int i = 0; i < NUM_BLOCKS; i++)
            links[i] = (i >= FIRST_DATA_BLOCK && i < NUM_BLOCKS - 1) ? 8'(i + 1) : 8'd0;
        free_ptr = 8'(FIRST_DATA_BLOCK);
        for (int i = 0; i < ROOT_ENTRIES; i++)
        begin
            dir_used[i]  = 0;
            dir_first[i] = 0;
            dir_name[i]  = 0;
        end
    endfunction

    // apply one request to the shadow and return its outcome
    function automatic outcome_t run_request(logic [2:0] op, logic [63:0] nm,
                                             logic [7:0] blk);
        outcome_t r;
        int e;
        int cur;
        int steps;
        logic [7:0] alloc;
        r.st = ST_OK;
        r.val = 0;
        e = lookup(nm);
        case (op)
            OP_CREATE:
            begin
                if (e >= 0)
                    r.st = ST_EXISTS;
                else
                begin
                    r.st = ST_DIR_FULL;
                    for (int i = 0; i < ROOT_ENTRIES; i++)
                        if (!dir_used[i])
                        begin
                            dir_used[i]  = 1;
                            dir_name[i]  = nm;
                            dir_first[i] = 0;
                            r.st = ST_OK;
                            break;
                        end
                end
            end
            OP_REMOVE:
            begin
                if (e < 0)
                    r.st = ST_NO_FILE;
                else if (dir_first[e] != 0)
                    r.st = ST_NOT_EMPTY;
                else
                    dir_used[e] = 0;
            end
            OP_APPEND:
            begin
                if (e < 0)
                    r.st = ST_NO_FILE;
                else if (free_ptr == 0)
                    r.st = ST_DISK_FULL;
                else
                begin
                    alloc = free_ptr;
                    free_ptr = link_of(alloc);
                    links[alloc] = 0;
                    if (dir_first[e] == 0)
                        dir_first[e] = alloc;
                    else
                    begin
                        cur = dir_first[e];
                        steps = 0;
                        while (link_of(cur) != 0 && steps < NUM_BLOCKS)
                        begin
                            cur = link_of(cur);
                            steps++;
                        end
                        if (cur < NUM_BLOCKS)
                            links[cur] = alloc;
                    end
                    r.val = alloc;
                end
            end
            OP_DELETE:
            begin
                if (e < 0)
                    r.st = ST_NO_FILE;
                else if (!chain_has(dir_first[e], blk))
                    r.st = ST_NOT_IN_FILE;
                else
                begin
                    if (dir_first[e] == blk)
                        dir_first[e] = link_of(blk);
                    else
                    begin
                        cur = dir_first[e];
                        steps = 0;
                        while (link_of(cur) != blk && steps < NUM_BLOCKS)
                        begin
                            cur = link_of(cur);
                            steps++;
                        end
                        if (cur < NUM_BLOCKS)
                            links[cur] = link_of(blk);
                    end
                    links[blk] = free_ptr;
                    free_ptr = blk;
                end
            end
            OP_CHECK:
            begin
                if (e < 0)
                    r.st = ST_NO_FILE;
                else if (!chain_has(dir_first[e], blk))
                    r.st = ST_NOT_IN_FILE;
            end
            OP_NEXT:
            begin
                if (e < 0)
                    r.st = ST_NO_FILE;
                else if (!chain_has(dir_first[e], blk))
                    r.st = ST_NOT_IN_FILE;
                else
                    r.val = link_of(blk);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    initial
        format_disk();

    // predict on request transfer, compare on response transfer
    always @(posedge clk)
    begin
        outcome_t exp_o;
        int bad;
        bad = 0;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("unexpected response: status %0d block_value %0d",
                           status, block_value);
                    bad++;
                end
                else
                begin
                    exp_o = expected_outcomes.pop_front();
                    if (status !== exp_o.st)
                    begin
                        $error("status: expected %0d actual %0d", exp_o.st, status);
                        bad++;
                    end
                    if (block_value !== exp_o.val)
                    begin
                        $error("block_value: expected %0d actual %0d",
                               exp_o.val, block_value);
                        bad++;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_outcomes = {expected_outcomes,
                                     run_request(opcode, file_name, block_number)};
        end
        if (bad != 0)
            fail_count <= fail_count + bad;
    end

    initial
        fail_count = 0;

endmodule

>>> tb/tb_fat_chain_allocator.sv
// tb_fat_chain_allocator: drives directed and random file-system requests into
// the allocator with bursty requests and a stalling receiver
// depends on fca_pkg, fat_chain_allocator and fca_checker
`timescale 1ns / 1ps

module tb_fat_chain_allocator;
    import fca_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int FIRST_BLOCK_GUESS = DEF_FIRST_DATA_BLOCK;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [2:0]  opcode;
    logic [63:0] file_name;
    logic [7:0]  block_number;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [2:0]  status;
    logic [7:0]  block_value;
    int          fail_count;
    int          pending;
    int          cycles;

    // small pool of names, so requests hit existing files often
    logic [63:0] names [24];

    fat_chain_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .opcode(opcode), .file_name(file_name), .block_number(block_number),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .status(status), .block_value(block_value)
    );

    fca_checker chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .opcode(opcode), .file_name(file_name), .block_number(block_number),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .status(status), .block_value(block_value),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall pattern: long ready runs alternating with stall runs
    initial
    begin
        int run;
        rsp_ready = 1'b0;
        forever
        begin
            run = $urandom_range(1, 40);
            repeat (run) @(posedge clk) rsp_ready <= 1'b1;
            run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (run) @(posedge clk) rsp_ready <= 1'b0;
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_fat_chain_allocator: done, errors");
            $finish;
        end
    end

    // one request transfer; valid stays high when the next follows at once
    task automatic send(logic [2:0] op, logic [63:0] nm, logic [7:0] blk);
        req_valid    <= 1'b1;
        opcode       <= op;
        file_name    <= nm;
        block_number <= blk;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic idle_gap(int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_block();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        if (r < 7)
            return 8'($urandom_range(FIRST_BLOCK_GUESS, FIRST_BLOCK_GUESS + 40));
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int burst;
        logic [2:0] op;
        logic [63:0] nm;
        cycles       = 0;
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        opcode       = OP_CREATE;
        file_name    = 64'd0;
        block_number = 8'd0;
        for (int i = 0; i < 24; i++)
            names[i] = {$urandom, $urandom};
        names[0] = 64'd0;
        names[1] = '1;
        names[2] = "xxxxxxxx";
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every opcode, special cases
        send(OP_APPEND, names[0], 8'd0);      // append to unknown file
        send(OP_REMOVE, names[1], 8'd0);      // remove unknown
        send(OP_CHECK, names[1], 8'd0);
        send(OP_CREATE, names[0], 8'd0);
        send(OP_CREATE, names[0], 8'd0);      // exists
        send(OP_CREATE, names[1], 8'd0);
        send(OP_CREATE, names[2], 8'd0);
        send(OP_APPEND, names[1], 8'd0);
        send(OP_APPEND, names[1], 8'd0);
        send(OP_APPEND, names[1], 8'd0);
        send(OP_REMOVE, names[1], 8'd0);      // not empty
        send(OP_NEXT, names[1], 8'd11);
        send(OP_NEXT, names[1], 8'd13);       // end of chain
        send(OP_CHECK, names[1], 8'd0);       // block zero never in chain
        send(OP_CHECK, names[1], 8'd255);
        send(OP_DELETE, names[1], 8'd12);     // middle of chain
        send(OP_DELETE, names[0], 8'd12);     // not in file
        send(OP_DELETE, names[1], 8'd11);     // head of chain
        send(OP_DELETE, names[1], 8'd13);
        send(3'd6, names[1], 8'd255);         // unused opcodes
        send(3'd7, names[0], 8'd0);
        send(OP_REMOVE, names[1], 8'd0);
        for (int i = 3; i < 21; i++)          // fill the directory
            send(OP_CREATE, names[i], 8'd0);
        idle_gap(3);

        // random bursts; appends weighted so the disk fills and drains
        for (int n = 0; n < RANDOM_ITEMS; )
        begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++)
            begin
                case ($urandom_range(0, 15))
                    0, 1:       op = OP_CREATE;
                    2:          op = OP_REMOVE;
                    3, 4, 5, 6: op = (n % 600 < 350) ? OP_APPEND : OP_DELETE;
                    7, 8, 9:    op = OP_DELETE;
                    10, 11:     op = OP_CHECK;
                    12, 13:     op = OP_NEXT;
                    default:    op = 3'($urandom_range(0, 7));
                endcase
                nm = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                                  : names[$urandom_range(0, 23)];
                send(op, nm, pick_block());
            end
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
        end

        // drain
        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (fail_count == 0)
            $display("tb_fat_chain_allocator: done, clean");
        else
            $display("tb_fat_chain_allocator: done, errors");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/fca_pkg.sv
hw/rtl/fat_chain_allocator.sv
tb/fca_checker.sv
tb/tb_fat_chain_allocator.sv
